[sv/i2c_master_byte_engine_unit_defines.svh]
// ----------------------------------------------------------------------------
// I2C byte engine assertion macros
// Concurrent assertion helpers shared by the engine's RTL files.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge, suspended while reset is asserted.
`define IBE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ibe assertion failed");
// Checked on every rising edge, reset included.
`define IBE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ibe assertion failed");
`else
`define IBE_ASSERT(lbl, clk, rst_n, prop)
`define IBE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[sv/ibe_pkg.sv]
// ----------------------------------------------------------------------------
// I2C byte engine package
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package ibe_pkg;

  localparam int unsigned QuarterW     = 10;
  localparam logic [QuarterW-1:0] QuarterReset = 10'd5;
  localparam int unsigned QueueDepth   = 2;

  // Command codes as they arrive on the input channel.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // One classified tick as it travels from the front to the back.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data_byte;
    logic       ack_reply;
    logic       sda_sample;
  } tick_t;

  localparam int unsigned TickW = $bits(tick_t);

endpackage

[sv/i2c_master_byte_engine_unit.sv]
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master pin sequencer for start, stop, byte write and read.
// ----------------------------------------------------------------------------
// Usage: every input transaction is one bus time tick. It carries the sampled
// SDA level and optionally a command (start, stop, write byte, read byte).
// Each accepted tick yields exactly one output transaction with the SCL/SDA
// pin levels, the SDA drive enable, busy, a done pulse, the last read byte,
// the last write acknowledge and a rejection flag for commands seen while
// busy. Bit timing is set through cfg_we_i/cfg_wdata_i as a number of ticks
// per quarter bit period; write it only while the engine is idle.
// A tick is written into the queue at its accepting edge and stepped by the
// sequencer once the result slot is free or being emptied; its result is then
// held in the output register. The engine takes one tick per cycle while the
// receiver does not stall; the single sequencer step per tick is the limit.
// When the receiver stalls, the held result stays put, the sequencer freezes
// and the queue fills; once it is full in_stall_o rises. Reset returns the
// bus to idle (SCL and SDA high, SDA driven), a quarter period of 5 ticks,
// an empty queue and no pending output.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit #(
  parameter int unsigned QueueDepth = ibe_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ibe_pkg::QuarterW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   cmd_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         ack_reply_i,
  input  logic                         sda_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         scl_level_o,
  output logic                         sda_level_o,
  output logic                         sda_drive_o,
  output logic                         busy_res_o,
  output logic                         done_res_o,
  output logic [7:0]                   read_byte_o,
  output logic                         ack_ok_o,
  output logic                         cmd_rejected_o
);

  ibe_pkg::tick_t            front_tick;
  ibe_pkg::tick_t            back_tick;
  logic [ibe_pkg::TickW-1:0] back_bits;
  logic                      q_full, q_valid, q_pop;

  // Front: classify the tick; undefined command codes become plain ticks.
  ibe_front u_front (
    .cmd_i        (cmd_i),
    .data_byte_i  (data_byte_i),
    .ack_reply_i  (ack_reply_i),
    .sda_sample_i (sda_sample_i),
    .tick_o       (front_tick)
  );

  // The queue is the only place that can push back on the input channel.
  assign in_stall_o = q_full;

  ibe_queue #(
    .Width (ibe_pkg::TickW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_tick),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (back_bits)
  );

  assign back_tick = ibe_pkg::tick_t'(back_bits);

  // Back: one sequencer step per tick, results held in its output register.
  ibe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .tick_valid_i   (q_valid),
    .tick_i         (back_tick),
    .tick_pop_o     (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scl_level_o    (scl_level_o),
    .sda_level_o    (sda_level_o),
    .sda_drive_o    (sda_drive_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .read_byte_o    (read_byte_o),
    .ack_ok_o       (ack_ok_o),
    .cmd_rejected_o (cmd_rejected_o)
  );

endmodule

[sv/ibe_front.sv]
// ----------------------------------------------------------------------------
// I2C byte engine front
// Classifies each incoming tick and folds undefined command codes to none.
// ----------------------------------------------------------------------------
module ibe_front (
  input  logic          [2:0] cmd_i,
  input  logic          [7:0] data_byte_i,
  input  logic                ack_reply_i,
  input  logic                sda_sample_i,
  output ibe_pkg::tick_t      tick_o
);

  ibe_pkg::cmd_e kind;

  // Codes above read carry no meaning and are treated as a plain tick.
  always_comb begin
    case (cmd_i)
      ibe_pkg::CMD_START,
      ibe_pkg::CMD_STOP,
      ibe_pkg::CMD_WRITE,
      ibe_pkg::CMD_READ: kind = ibe_pkg::cmd_e'(cmd_i);
      default:           kind = ibe_pkg::CMD_NONE;
    endcase
  end

  assign tick_o.cmd        = kind;
  assign tick_o.data_byte  = data_byte_i;
  assign tick_o.ack_reply  = ack_reply_i;
  assign tick_o.sda_sample = sda_sample_i;

endmodule

[sv/ibe_queue.sv]
// ----------------------------------------------------------------------------
// I2C byte engine queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_unit_defines.svh"

module ibe_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = store_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The fill level never leaves the range the storage can hold.
  `IBE_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CntW'(Depth))
  // A pop on an empty queue would hand a stale entry to the back.
  `IBE_ASSERT(a_pop_count, clk_i, rst_ni,
              (pop_i && !valid_o && !push_i) |=> (count_q == $past(count_q)))

endmodule

[sv/ibe_back.sv]
// ----------------------------------------------------------------------------
// I2C byte engine back
// Pin sequencer: runs start, stop, write and read segments tick by tick and
// holds the result registers that feed the output channel.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_unit_defines.svh"

module ibe_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ibe_pkg::QuarterW-1:0]    cfg_wdata_i,
  input  logic                            tick_valid_i,
  input  ibe_pkg::tick_t                  tick_i,
  output logic                            tick_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            scl_level_o,
  output logic                            sda_level_o,
  output logic                            sda_drive_o,
  output logic                            busy_res_o,
  output logic                            done_res_o,
  output logic [7:0]                      read_byte_o,
  output logic                            ack_ok_o,
  output logic                            cmd_rejected_o
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_ST_C    = 5'd3,
    PH_SP_A    = 5'd4,
    PH_SP_B    = 5'd5,
    PH_WR_LO   = 5'd6,
    PH_WR_DAT  = 5'd7,
    PH_WR_HI   = 5'd8,
    PH_WA_REL  = 5'd9,
    PH_WA_HI   = 5'd10,
    PH_WA_NACK = 5'd11,
    PH_WA_END  = 5'd12,
    PH_RD_LO   = 5'd13,
    PH_RD_HI   = 5'd14,
    PH_RD_SMP  = 5'd15,
    PH_RA_LO   = 5'd16,
    PH_RA_SET  = 5'd17,
    PH_RA_HI   = 5'd18
  } phase_e;

  phase_e                         phase_q, phase_d;
  logic [3:0]                     bit_q, bit_d;
  logic [7:0]                     shift_q, shift_d;
  logic [11:0]                    wait_q, wait_d;
  logic                           scl_q, scl_d, sda_q, sda_d, oe_q, oe_d;
  logic                           ack_q, ack_d, choice_q, choice_d;
  ibe_pkg::cmd_e                  cur_q, cur_d;
  logic [7:0]                     rdres_q, rdres_d;
  logic [ibe_pkg::QuarterW-1:0]   quarter_q;
  logic                           done_q, done_d, rej_q, rej_d;
  logic                           oval_q, oval_d;
  logic                           fire, known;

  // A tick is processed when the result slot is free or being emptied.
  assign fire       = tick_valid_i && (!oval_q || !out_stall_i);
  assign tick_pop_o = fire;
  assign known      = (tick_i.cmd != ibe_pkg::CMD_NONE);

  always_comb begin
    phase_e                       nx;
    logic                         enter_en;
    logic [1:0]                   len_sh;
    logic [ibe_pkg::QuarterW-1:0] q_eff;
    logic [11:0]                  span;

    phase_d  = phase_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    wait_d   = wait_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    oe_d     = oe_q;
    ack_d    = ack_q;
    choice_d = choice_q;
    cur_d    = cur_q;
    rdres_d  = rdres_q;
    done_d   = done_q;
    rej_d    = rej_q;
    oval_d   = fire || (oval_q && out_stall_i);
    nx       = PH_IDLE;
    enter_en = 1'b0;
    len_sh   = 2'd0;
    q_eff    = (quarter_q == '0) ? ibe_pkg::QuarterW'(1) : quarter_q;
    span     = 12'({2'b00, q_eff} << len_sh);

    if (fire) begin
      done_d = 1'b0;
      rej_d  = 1'b0;
      if (phase_q != PH_IDLE) begin
        rej_d = known;
        if (wait_q != '0) begin
          wait_d = wait_q - 12'd1;
        end else begin
          case (phase_q)
            PH_ST_A:   nx = PH_ST_B;
            PH_ST_B:   nx = PH_ST_C;
            PH_SP_A:   nx = PH_SP_B;
            PH_WR_LO:  nx = PH_WR_DAT;
            PH_WR_DAT: nx = PH_WR_HI;
            PH_WR_HI: begin
              shift_d = {shift_q[6:0], 1'b0};
              bit_d   = bit_q + 4'd1;
              nx      = (bit_d >= 4'd8) ? PH_WA_REL : PH_WR_LO;
            end
            PH_WA_REL: nx = PH_WA_HI;
            PH_WA_HI: begin
              if (tick_i.sda_sample) begin
                nx = PH_WA_NACK;
              end else begin
                ack_d = 1'b1;
                nx    = PH_WA_END;
              end
            end
            PH_WA_NACK: nx = PH_WA_END;
            PH_RD_LO:   nx = PH_RD_HI;
            PH_RD_HI:   nx = PH_RD_SMP;
            PH_RD_SMP: begin
              bit_d = bit_q + 4'd1;
              nx    = (bit_d >= 4'd8) ? PH_RA_LO : PH_RD_LO;
            end
            PH_RA_LO:  nx = PH_RA_SET;
            PH_RA_SET: nx = PH_RA_HI;
            default:   nx = PH_IDLE;
          endcase
          if (nx == PH_IDLE) begin
            if (cur_q == ibe_pkg::CMD_WRITE) begin
              oe_d = 1'b1;
            end
            if (cur_q == ibe_pkg::CMD_READ) begin
              rdres_d = shift_d;
            end
            phase_d = PH_IDLE;
            wait_d  = '0;
            done_d  = 1'b1;
          end else begin
            enter_en = 1'b1;
          end
        end
      end else if (known) begin
        cur_d    = tick_i.cmd;
        bit_d    = '0;
        enter_en = 1'b1;
        case (tick_i.cmd)
          ibe_pkg::CMD_START: nx = PH_ST_A;
          ibe_pkg::CMD_STOP:  nx = PH_SP_A;
          ibe_pkg::CMD_WRITE: begin
            shift_d = tick_i.data_byte;
            nx      = PH_WR_LO;
          end
          default: begin
            choice_d = tick_i.ack_reply;
            shift_d  = '0;
            nx       = PH_RD_LO;
          end
        endcase
      end

      // Segment entry: pin actions, then the segment length in quarters.
      if (enter_en) begin
        phase_d = nx;
        case (nx)
          PH_ST_A: begin oe_d = 1'b1; sda_d = 1'b1; end
          PH_ST_B: scl_d = 1'b1;
          PH_ST_C: sda_d = 1'b0;
          PH_SP_A: begin oe_d = 1'b1; sda_d = 1'b0; scl_d = 1'b1; end
          PH_SP_B: sda_d = 1'b1;
          PH_WR_LO: begin scl_d = 1'b0; oe_d = 1'b1; end
          PH_WR_DAT: sda_d = shift_d[7];
          PH_WR_HI: begin scl_d = 1'b1; len_sh = 2'd1; end
          PH_WA_REL: begin
            scl_d = 1'b0; oe_d = 1'b0; sda_d = 1'b1; len_sh = 2'd1;
          end
          PH_WA_HI: begin scl_d = 1'b1; len_sh = 2'd1; end
          PH_WA_NACK: begin
            oe_d = 1'b1; scl_d = 1'b0; ack_d = 1'b0; len_sh = 2'd2;
          end
          PH_WA_END: begin scl_d = 1'b0; len_sh = 2'd2; end
          PH_RD_LO: begin
            shift_d = {shift_d[6:0], 1'b0};
            scl_d = 1'b0; oe_d = 1'b0; sda_d = 1'b1; len_sh = 2'd1;
          end
          PH_RD_HI: scl_d = 1'b1;
          PH_RD_SMP: shift_d = {shift_d[7:1], shift_d[0] | tick_i.sda_sample};
          PH_RA_LO: begin scl_d = 1'b0; oe_d = 1'b1; len_sh = 2'd1; end
          PH_RA_SET: begin sda_d = !choice_d; len_sh = 2'd1; end
          PH_RA_HI: begin scl_d = 1'b1; len_sh = 2'd1; end
          default: ;
        endcase
        span   = 12'({2'b00, q_eff} << len_sh);
        wait_d = span - 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_q     <= '0;
      shift_q   <= '0;
      wait_q    <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      oe_q      <= 1'b1;
      ack_q     <= 1'b1;
      choice_q  <= 1'b0;
      cur_q     <= ibe_pkg::CMD_NONE;
      rdres_q   <= '0;
      quarter_q <= ibe_pkg::QuarterReset;
      done_q    <= 1'b0;
      rej_q     <= 1'b0;
      oval_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      wait_q   <= wait_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      oe_q     <= oe_d;
      ack_q    <= ack_d;
      choice_q <= choice_d;
      cur_q    <= cur_d;
      rdres_q  <= rdres_d;
      done_q   <= done_d;
      rej_q    <= rej_d;
      oval_q   <= oval_d;
      if (cfg_we_i) begin
        quarter_q <= cfg_wdata_i;
      end
    end
  end

  assign out_valid_o    = oval_q;
  assign scl_level_o    = scl_q;
  assign sda_level_o    = sda_q;
  assign sda_drive_o    = oe_q;
  assign busy_res_o     = (phase_q != PH_IDLE);
  assign done_res_o     = done_q;
  assign read_byte_o    = rdres_q;
  assign ack_ok_o       = ack_q;
  assign cmd_rejected_o = rej_q;

  // The completion tick always reports the engine as idle.
  `IBE_ASSERT(a_done_idle, clk_i, rst_ni, done_q |-> (phase_q == PH_IDLE))
  // No segment counter runs while the engine is idle.
  `IBE_ASSERT(a_idle_wait, clk_i, rst_ni, (phase_q == PH_IDLE) |-> (wait_q == '0))
  // Bit counter never passes the byte length.
  `IBE_ASSERT(a_bit_range, clk_i, rst_ni, bit_q <= 4'd8)
  // While the result waits, the sequencer does not advance.
  `IBE_ASSERT(a_hold_state, clk_i, rst_ni,
              (oval_q && out_stall_i) |=> ($stable(phase_q) && $stable(wait_q)))

endmodule

[bench/i2c_master_byte_engine_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Drives bus ticks with start, stop, write and read commands into the engine
// and checks every per-tick pin transaction against an in-bench sequencer
// model. A short scripted walk covers the corner cases and is followed by
// random command sequences over several quarter-period settings, with random
// gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit_test;

  // Command codes the engine does not know; they must be ignored silently.
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam int         KeepQuarter = -1;
  localparam int         RandomPhases = 7;
  localparam int         TicksPerPhase = 115;

  // Segments of the bus sequence as this bench models them.
  typedef enum logic [4:0] {
    BUS_IDLE, START_SDA_HI, START_SCL_HI, START_SDA_LO, STOP_SDA_LO, STOP_SDA_HI,
    WR_SCL_LO, WR_DATA, WR_SCL_HI, WACK_RELEASE, WACK_SCL_HI, WACK_NACK, WACK_END,
    RD_SCL_LO, RD_SCL_HI, RD_SAMPLE, RACK_SCL_LO, RACK_SET, RACK_SCL_HI
  } seq_phase_e;

  // Pin and status state reported for one tick.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    logic [7:0] rd;
    logic       ack;
    logic       rej;
  } pin_state_t;

  typedef struct {
    logic [2:0] cmd;
    logic [7:0] data;
    logic       sack;
    logic       smp;
    int         new_q;    // quarter period to set before the row, or KeepQuarter
    bit         pad;      // keep ticking until the engine is idle again
    logic [2:0] end_cmd;  // command sent on the completion tick while padding
    bit         typed;    // expected state below is known by hand
    pin_state_t res;
  } script_row_t;

  localparam pin_state_t NO_RES = '0;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [ibe_pkg::QuarterW-1:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] cmd_i = ibe_pkg::CMD_NONE;
  logic [7:0] data_byte_i = '0;
  logic       ack_reply_i = 1'b0;
  logic       sda_sample_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       scl_level_o;
  logic       sda_level_o;
  logic       sda_drive_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] read_byte_o;
  logic       ack_ok_o;
  logic       cmd_rejected_o;

  // Sequencer model state, starting from the reset values.
  seq_phase_e    seq_ph = BUS_IDLE;
  logic [3:0]    bits_done = '0;
  logic [7:0]    shreg = '0;
  logic [11:0]   wait_left = '0;
  logic          scl_q = 1'b1;
  logic          sda_q = 1'b1;
  logic          oe_q = 1'b1;
  logic          ack_q = 1'b1;
  logic [2:0]    cur_cmd = ibe_pkg::CMD_NONE;
  logic          ack_sel = 1'b0;
  logic [7:0]    last_read = '0;
  logic [ibe_pkg::QuarterW-1:0] quarter_q = ibe_pkg::QuarterReset;

  pin_state_t    expected_pins_q[$];
  logic [2:0]    cmd_plan_q[$];
  int            fail_count = 0;
  int            send_idle_pct = 18;
  int            recv_idle_pct = 56;
  bit            hold_req = 1'b0;
  int            hold_left = 0;
  int            ticks;

  int            quarter_plan[RandomPhases] = '{1, 3, 2, 0, 4, 1, 2};

  // Scripted corner cases. The first rows run at the reset quarter period.
  script_row_t script[24] = '{
    '{ibe_pkg::CMD_NONE,  8'h00, 1'b0, 1'b0, KeepQuarter, 1'b0, ibe_pkg::CMD_NONE,  1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0}},
    '{ibe_pkg::CMD_STOP,  8'h00, 1'b0, 1'b0, KeepQuarter, 1'b0, ibe_pkg::CMD_NONE,  1'b1,
      '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0}},
    '{ibe_pkg::CMD_START, 8'h00, 1'b0, 1'b0, KeepQuarter, 1'b1, ibe_pkg::CMD_NONE,  1'b1,
      '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1}},
    '{ibe_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b1, 1,           1'b1, ibe_pkg::CMD_NONE,  1'b0,
      NO_RES},
    '{ibe_pkg::CMD_NONE,  8'h00, 1'b0, 1'b1, KeepQuarter, 1'b0, ibe_pkg::CMD_NONE,  1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{ibe_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b0, KeepQuarter, 1'b1, ibe_pkg::CMD_NONE,  1'b0,
      NO_RES},
    '{ibe_pkg::CMD_NONE,  8'h00, 1'b0, 1'b0, KeepQuarter, 1'b0, ibe_pkg::CMD_NONE,  1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0}},
    '{ibe_pkg::CMD_READ,  8'h00, 1'b1, 1'b1, KeepQuarter, 1'b1, ibe_pkg::CMD_NONE,  1'b0,
      NO_RES},
    '{ibe_pkg::CMD_NONE,  8'h00, 1'b0, 1'b0, KeepQuarter, 1'b0, ibe_pkg::CMD_NONE,  1'b1,
      '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'hFF, 1'b1, 1'b0}},
    '{ibe_pkg::CMD_READ,  8'h00, 1'b0, 1'b0, KeepQuarter, 1'b1, ibe_pkg::CMD_WRITE, 1'b0,
      NO_RES},
    '{ibe_pkg::CMD_NONE,  8'h00, 1'b0, 1'b0, KeepQuarter, 1'b0, ibe_pkg::CMD_NONE,  1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0}},
    '{ibe_pkg::CMD_START, 8'h00, 1'b0, 1'b0, KeepQuarter, 1'b1, CMD_RSVD6,          1'b0,
      NO_RES},
    '{ibe_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b0, KeepQuarter, 1'b1, ibe_pkg::CMD_NONE,  1'b0,
      NO_RES},
    '{CMD_RSVD5,          8'h00, 1'b0, 1'b0, KeepQuarter, 1'b0, ibe_pkg::CMD_NONE,  1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0}},
    '{CMD_RSVD7,          8'hFF, 1'b1, 1'b1, KeepQuarter, 1'b0, ibe_pkg::CMD_NONE,  1'b0,
      NO_RES},
    '{ibe_pkg::CMD_READ,  8'h00, 1'b1, 1'b0, KeepQuarter, 1'b0, ibe_pkg::CMD_NONE,  1'b0,
      NO_RES},
    '{CMD_RSVD6,          8'h00, 1'b0, 1'b1, KeepQuarter, 1'b0, ibe_pkg::CMD_NONE,  1'b0,
      NO_RES},
    '{ibe_pkg::CMD_STOP,  8'h00, 1'b0, 1'b0, KeepQuarter, 1'b1, ibe_pkg::CMD_START, 1'b0,
      NO_RES},
    '{ibe_pkg::CMD_STOP,  8'h00, 1'b0, 1'b1, KeepQuarter, 1'b1, ibe_pkg::CMD_NONE,  1'b0,
      NO_RES},
    '{ibe_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 0,           1'b1, ibe_pkg::CMD_READ,  1'b0,
      NO_RES},
    '{ibe_pkg::CMD_WRITE, 8'h3C, 1'b0, 1'b1, KeepQuarter, 1'b1, ibe_pkg::CMD_NONE,  1'b0,
      NO_RES},
    '{ibe_pkg::CMD_STOP,  8'h00, 1'b0, 1'b0, KeepQuarter, 1'b1, ibe_pkg::CMD_NONE,  1'b0,
      NO_RES},
    '{ibe_pkg::CMD_STOP,  8'h00, 1'b0, 1'b0, 64,          1'b1, ibe_pkg::CMD_STOP,  1'b0,
      NO_RES},
    '{ibe_pkg::CMD_NONE,  8'h00, 1'b0, 1'b0, KeepQuarter, 1'b0, ibe_pkg::CMD_NONE,  1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}}
  };

  i2c_master_byte_engine_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .data_byte_i    (data_byte_i),
    .ack_reply_i    (ack_reply_i),
    .sda_sample_i   (sda_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scl_level_o    (scl_level_o),
    .sda_level_o    (sda_level_o),
    .sda_drive_o    (sda_drive_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .read_byte_o    (read_byte_o),
    .ack_ok_o       (ack_ok_o),
    .cmd_rejected_o (cmd_rejected_o)
  );

  always #5 clk_i = ~clk_i;

  // Enter a segment: apply its pin actions and load its length in ticks.
  function automatic void enter_seg(seq_phase_e p, logic smp);
    int quarters;
    int qt;
    quarters = 1;
    seq_ph = p;
    case (p)
      START_SDA_HI: begin oe_q = 1'b1; sda_q = 1'b1; end
      START_SCL_HI: scl_q = 1'b1;
      START_SDA_LO: sda_q = 1'b0;
      STOP_SDA_LO:  begin oe_q = 1'b1; sda_q = 1'b0; scl_q = 1'b1; end
      STOP_SDA_HI:  sda_q = 1'b1;
      WR_SCL_LO:    begin scl_q = 1'b0; oe_q = 1'b1; end
      WR_DATA:      sda_q = shreg[7];
      WR_SCL_HI:    begin scl_q = 1'b1; quarters = 2; end
      WACK_RELEASE: begin scl_q = 1'b0; oe_q = 1'b0; sda_q = 1'b1; quarters = 2; end
      WACK_SCL_HI:  begin scl_q = 1'b1; quarters = 2; end
      WACK_NACK:    begin oe_q = 1'b1; scl_q = 1'b0; ack_q = 1'b0; quarters = 4; end
      WACK_END:     begin scl_q = 1'b0; quarters = 4; end
      RD_SCL_LO: begin
        shreg = shreg << 1;
        scl_q = 1'b0; oe_q = 1'b0; sda_q = 1'b1; quarters = 2;
      end
      RD_SCL_HI:    scl_q = 1'b1;
      RD_SAMPLE:    shreg[0] = shreg[0] | smp;
      RACK_SCL_LO:  begin scl_q = 1'b0; oe_q = 1'b1; quarters = 2; end
      RACK_SET:     begin sda_q = ack_sel ? 1'b0 : 1'b1; quarters = 2; end
      RACK_SCL_HI:  begin scl_q = 1'b1; quarters = 2; end
      default:      seq_ph = BUS_IDLE;
    endcase
    // A zero quarter period behaves as a single tick.
    qt = (quarter_q == '0) ? 1 : int'(quarter_q);
    wait_left = 12'(qt * quarters - 1);
  endfunction

  // Advance the model by one tick and return the state the engine should show.
  function automatic pin_state_t sequence_tick(logic [2:0] cmd, logic [7:0] data,
                                               logic sack, logic smp);
    pin_state_t r;
    bit         known;
    seq_phase_e nx;
    r = '0;
    known = (cmd >= ibe_pkg::CMD_START) && (cmd <= ibe_pkg::CMD_READ);
    if (seq_ph != BUS_IDLE) begin
      r.rej = known;
      if (wait_left != '0) begin
        wait_left = wait_left - 1'b1;
      end else begin
        nx = BUS_IDLE;
        case (seq_ph)
          START_SDA_HI: nx = START_SCL_HI;
          START_SCL_HI: nx = START_SDA_LO;
          STOP_SDA_LO:  nx = STOP_SDA_HI;
          WR_SCL_LO:    nx = WR_DATA;
          WR_DATA:      nx = WR_SCL_HI;
          WR_SCL_HI: begin
            shreg = shreg << 1;
            bits_done = bits_done + 1'b1;
            nx = (bits_done >= 4'd8) ? WACK_RELEASE : WR_SCL_LO;
          end
          WACK_RELEASE: nx = WACK_SCL_HI;
          WACK_SCL_HI: begin
            // SDA still high here means the slave did not acknowledge.
            if (smp) begin
              nx = WACK_NACK;
            end else begin
              ack_q = 1'b1;
              nx = WACK_END;
            end
          end
          WACK_NACK:    nx = WACK_END;
          RD_SCL_LO:    nx = RD_SCL_HI;
          RD_SCL_HI:    nx = RD_SAMPLE;
          RD_SAMPLE: begin
            bits_done = bits_done + 1'b1;
            nx = (bits_done >= 4'd8) ? RACK_SCL_LO : RD_SCL_LO;
          end
          RACK_SCL_LO:  nx = RACK_SET;
          RACK_SET:     nx = RACK_SCL_HI;
          default:      nx = BUS_IDLE;
        endcase
        if (nx == BUS_IDLE) begin
          if (cur_cmd == ibe_pkg::CMD_WRITE) oe_q = 1'b1;
          if (cur_cmd == ibe_pkg::CMD_READ) last_read = shreg;
          seq_ph = BUS_IDLE;
          wait_left = '0;
          r.done = 1'b1;
        end else begin
          enter_seg(nx, smp);
        end
      end
    end else if (known) begin
      cur_cmd = cmd;
      bits_done = '0;
      case (cmd)
        ibe_pkg::CMD_START: enter_seg(START_SDA_HI, smp);
        ibe_pkg::CMD_STOP:  enter_seg(STOP_SDA_LO, smp);
        ibe_pkg::CMD_WRITE: begin
          shreg = data;
          enter_seg(WR_SCL_LO, smp);
        end
        default: begin
          ack_sel = sack;
          shreg = '0;
          enter_seg(RD_SCL_LO, smp);
        end
      endcase
    end
    r.scl  = scl_q;
    r.sda  = sda_q;
    r.drv  = oe_q;
    r.busy = (seq_ph != BUS_IDLE);
    r.rd   = last_read;
    r.ack  = ack_q;
    return r;
  endfunction

  // True when the next tick is the completion tick of the running command.
  function automatic bit ends_next();
    return (wait_left == '0) &&
           (seq_ph inside {START_SDA_LO, STOP_SDA_HI, WACK_END, RACK_SCL_HI});
  endfunction

  // Offer one tick at a falling edge and hold it until the engine takes it.
  task automatic send_tick(logic [2:0] cmd, logic [7:0] data, logic sack, logic smp,
                           bit typed = 1'b0, pin_state_t typed_res = '0);
    pin_state_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cmd_i        <= cmd;
    data_byte_i  <= data;
    ack_reply_i  <= sack;
    sda_sample_i <= smp;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = sequence_tick(cmd, data, sack, smp);
    expected_pins_q.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  // Let every outstanding transaction come back, plus the pipeline latency.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (expected_pins_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_quarter(int q);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ibe_pkg::QuarterW'(q);
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    quarter_q = ibe_pkg::QuarterW'(q);
  endtask

  // Mostly well-formed start/data/stop sequences, with stray and reserved
  // commands mixed in, plus extra commands aimed at the completion tick.
  task automatic random_tick();
    logic [2:0] c;
    int         roll;
    c = ibe_pkg::CMD_NONE;
    roll = $urandom_range(99);
    if (seq_ph == BUS_IDLE) begin
      if (roll < 30) begin
        if (cmd_plan_q.size() == 0) begin
          cmd_plan_q.push_back(ibe_pkg::CMD_START);
          repeat ($urandom_range(3, 1))
            cmd_plan_q.push_back($urandom_range(1) ? ibe_pkg::CMD_WRITE
                                                   : ibe_pkg::CMD_READ);
          cmd_plan_q.push_back(ibe_pkg::CMD_STOP);
        end
        c = cmd_plan_q.pop_front();
      end else if (roll < 36) begin
        c = 3'($urandom_range(7, 1));
      end
    end else if (ends_next()) begin
      if (roll < 40) c = 3'($urandom_range(7, 1));
    end else if (roll < 3) begin
      c = 3'($urandom_range(7, 1));
    end
    send_tick(c, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Output side: random stall, or a long hold-off when the stimulus asks.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Every transaction taken from the output is matched against the oldest
  // expected pin state.
  always @(posedge clk_i) begin
    pin_state_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pins_q.size() == 0) begin
        $error("result transaction with no tick outstanding");
        fail_count++;
      end else begin
        want = expected_pins_q.pop_front();
        check_field("scl_level", want.scl, scl_level_o);
        check_field("sda_level", want.sda, sda_level_o);
        check_field("sda_drive", want.drv, sda_drive_o);
        check_field("busy_res", want.busy, busy_res_o);
        check_field("done_res", want.done, done_res_o);
        check_field("read_byte", want.rd, read_byte_o);
        check_field("ack_ok", want.ack, ack_ok_o);
        check_field("cmd_rejected", want.rej, cmd_rejected_o);
      end
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Scripted walk, sender idling lightly and receiver heavily.
    foreach (script[i]) begin
      if (script[i].new_q != KeepQuarter) write_quarter(script[i].new_q);
      send_tick(script[i].cmd, script[i].data, script[i].sack, script[i].smp,
                script[i].typed, script[i].res);
      if (script[i].pad) begin
        while (seq_ph != BUS_IDLE)
          send_tick(ends_next() ? script[i].end_cmd : ibe_pkg::CMD_NONE, script[i].data,
                    script[i].sack, script[i].smp);
      end
    end

    // Random sequences; the idling pattern flips and then stops, and the
    // first gap-free phase starts with a long hold-off on the output.
    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 18;
      end else if (p == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_quarter(quarter_plan[p]);
      if (p == 5) hold_req = 1'b1;
      ticks = 0;
      while (ticks < TicksPerPhase || seq_ph != BUS_IDLE) begin
        random_tick();
        ticks++;
      end
    end

    settle_idle();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[i2c_master_byte_engine_unit] OK");
    end else begin
      $display("[i2c_master_byte_engine_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[i2c_master_byte_engine_unit] ERROR");
    $finish;
  end

endmodule
